FILE: design/bitmask_sprite_collision_top_defines.svh
// assertion macros for the bitmask sprite collision block
// used by bsc_ctrl and bsc_datapath; no other dependencies
`ifndef BITMASK_SPRITE_COLLISION_TOP_DEFINES_SVH
`define BITMASK_SPRITE_COLLISION_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define BSC_ASSERT_IMPLIES(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("bsc assertion failed");

// next-cycle implication, checked outside reset
`define BSC_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("bsc assertion failed");

`else

`define BSC_ASSERT_IMPLIES(label, clk, rstn, cond, prop)
`define BSC_ASSERT_NEXT(label, clk, rstn, cond, prop)

`endif

`endif

FILE: design/bsc_pkg.sv
// shared constants, codes and controller/datapath interface types
// for the bitmask sprite collision block; no dependencies
`default_nettype none

package bsc_pkg;

    localparam int unsigned DefMaxWidth    = 64;
    localparam int unsigned DefMaxHeight   = 64;
    localparam int unsigned DefWordsPerRow = 3;

    localparam int unsigned WordW    = 32;
    localparam int unsigned PosW     = 16;
    localparam int unsigned OffW     = 10;
    localparam int unsigned SizeW    = 7;
    localparam int unsigned LoadRowW = 6;
    localparam int unsigned LoadIdxW = 2;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;
    // screen coordinate plus offset plus size, signed
    localparam int unsigned CoordW   = 18;

    localparam logic KindLoad = 1'b0;
    localparam logic KindTest = 1'b1;
    localparam logic SelMaskA = 1'b0;
    localparam logic SelMaskB = 1'b1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_OFFSET_A_X = 3'd0,
        CFG_OFFSET_A_Y = 3'd1,
        CFG_WIDTH_A    = 3'd2,
        CFG_HEIGHT_A   = 3'd3,
        CFG_OFFSET_B_X = 3'd4,
        CFG_OFFSET_B_Y = 3'd5,
        CFG_WIDTH_B    = 3'd6,
        CFG_HEIGHT_B   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic load;     // write one mask word
        logic capture;  // latch test positions
        logic bounds;   // form rectangles
        logic clip;     // intersect rectangles
        logic size;     // overlap size and start offsets, clear walk state
        logic issue;    // read next overlap row
    } bsc_cmd_t;

    typedef struct packed {
        logic empty;     // no overlap to walk
        logic last_row;  // next issued row is the last one
        logic hit;       // a common set pixel was found
        logic busy;      // a row read is still in flight
    } bsc_status_t;

endpackage

`default_nettype wire

FILE: design/bsc_datapath.sv
// datapath: config registers, mask word banks, rectangle math and row compare
// depends on bsc_pkg and the assertion macro header
`default_nettype none
`include "bitmask_sprite_collision_top_defines.svh"

module bsc_datapath import bsc_pkg::*; #(
    parameter int unsigned MAX_WIDTH     = DefMaxWidth,
    parameter int unsigned MAX_HEIGHT    = DefMaxHeight,
    parameter int unsigned WORDS_PER_ROW = DefWordsPerRow
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bsc_cmd_t                   cmd,
    output bsc_status_t                status,
    input  logic                       cfg_write,
    input  logic [CfgIdxW-1:0]         cfg_index,
    input  logic [CfgDataW-1:0]        cfg_data,
    input  logic                       s_mask_select,
    input  logic [LoadRowW-1:0]        s_load_row,
    input  logic [LoadIdxW-1:0]        s_load_word_index,
    input  logic [WordW-1:0]           s_load_data,
    input  logic signed [PosW-1:0]     s_pos_a_x,
    input  logic signed [PosW-1:0]     s_pos_a_y,
    input  logic signed [PosW-1:0]     s_pos_b_x,
    input  logic signed [PosW-1:0]     s_pos_b_y
);

    localparam int unsigned RowW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned ColW    = $clog2(MAX_WIDTH);
    localparam int unsigned RowBits = WORDS_PER_ROW * WordW;
    localparam int unsigned ExtBits = RowBits + MAX_WIDTH;
    localparam int unsigned DiffW   = CoordW + 1;
    localparam logic [CoordW-1:0] MaxW = CoordW'(MAX_WIDTH);
    localparam logic [CoordW-1:0] MaxH = CoordW'(MAX_HEIGHT);

    function automatic logic [CoordW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                     input logic [CoordW-1:0] maxv);
        logic [CoordW-1:0] ext;
        ext = CoordW'(v);
        return (ext > maxv) ? maxv : ext;
    endfunction

    // configuration registers
    logic [OffW-1:0]  off_a_x_reg, off_a_y_reg, off_b_x_reg, off_b_y_reg;
    logic [SizeW-1:0] width_a_reg, height_a_reg, width_b_reg, height_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_a_x_reg  <= '0;
            off_a_y_reg  <= '0;
            width_a_reg  <= '0;
            height_a_reg <= '0;
            off_b_x_reg  <= '0;
            off_b_y_reg  <= '0;
            width_b_reg  <= '0;
            height_b_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_OFFSET_A_X: off_a_x_reg  <= cfg_data[OffW-1:0];
                CFG_OFFSET_A_Y: off_a_y_reg  <= cfg_data[OffW-1:0];
                CFG_WIDTH_A:    width_a_reg  <= cfg_data[SizeW-1:0];
                CFG_HEIGHT_A:   height_a_reg <= cfg_data[SizeW-1:0];
                CFG_OFFSET_B_X: off_b_x_reg  <= cfg_data[OffW-1:0];
                CFG_OFFSET_B_Y: off_b_y_reg  <= cfg_data[OffW-1:0];
                CFG_WIDTH_B:    width_b_reg  <= cfg_data[SizeW-1:0];
                CFG_HEIGHT_B:   height_b_reg <= cfg_data[SizeW-1:0];
            endcase
        end
    end

    // test setup: capture, bounds, clip, size
    logic signed [PosW-1:0]   pos_ax_reg, pos_ay_reg, pos_bx_reg, pos_by_reg;
    logic signed [CoordW-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [CoordW-1:0] axe_reg, aye_reg, bxe_reg, bye_reg;
    logic signed [CoordW-1:0] ax_next, ay_next, bx_next, by_next;
    logic signed [CoordW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [CoordW-1:0]        aw, ah, bw, bh;
    logic                     size_zero_reg;
    logic signed [DiffW-1:0]  w_full, h_full;
    logic                     empty_reg;
    logic [ColW:0]            w_reg;
    logic [RowW:0]            h_reg;
    logic [ColW-1:0]          ca_reg, cb_reg;
    logic [RowW-1:0]          ra_reg, rb_reg;

    always_comb begin
        aw = clamp_size(width_a_reg, MaxW);
        ah = clamp_size(height_a_reg, MaxH);
        bw = clamp_size(width_b_reg, MaxW);
        bh = clamp_size(height_b_reg, MaxH);
        ax_next = CoordW'(pos_ax_reg) + $signed(CoordW'(off_a_x_reg));
        ay_next = CoordW'(pos_ay_reg) + $signed(CoordW'(off_a_y_reg));
        bx_next = CoordW'(pos_bx_reg) + $signed(CoordW'(off_b_x_reg));
        by_next = CoordW'(pos_by_reg) + $signed(CoordW'(off_b_y_reg));
        w_full  = DiffW'(x1_reg) - DiffW'(x0_reg);
        h_full  = DiffW'(y1_reg) - DiffW'(y0_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pos_ax_reg <= s_pos_a_x;
            pos_ay_reg <= s_pos_a_y;
            pos_bx_reg <= s_pos_b_x;
            pos_by_reg <= s_pos_b_y;
        end
        if (cmd.bounds) begin
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
            bx_reg  <= bx_next;
            by_reg  <= by_next;
            axe_reg <= ax_next + $signed(aw);
            aye_reg <= ay_next + $signed(ah);
            bxe_reg <= bx_next + $signed(bw);
            bye_reg <= by_next + $signed(bh);
            size_zero_reg <= (aw == '0) || (ah == '0) || (bw == '0) || (bh == '0);
        end
        if (cmd.clip) begin
            x0_reg <= (ax_reg > bx_reg) ? ax_reg : bx_reg;
            y0_reg <= (ay_reg > by_reg) ? ay_reg : by_reg;
            x1_reg <= (axe_reg < bxe_reg) ? axe_reg : bxe_reg;
            y1_reg <= (aye_reg < bye_reg) ? aye_reg : bye_reg;
        end
        if (cmd.size) begin
            empty_reg <= size_zero_reg || w_full[DiffW-1] || (w_full == '0)
                         || h_full[DiffW-1] || (h_full == '0);
            w_reg  <= (ColW+1)'(w_full);
            h_reg  <= (RowW+1)'(h_full);
            ca_reg <= ColW'(x0_reg - ax_reg);
            cb_reg <= ColW'(x0_reg - bx_reg);
            ra_reg <= RowW'(y0_reg - ay_reg);
            rb_reg <= RowW'(y0_reg - by_reg);
        end
    end

    // mask word banks, one per word of a row
    logic             load_en;
    logic [RowW-1:0]  load_addr;
    logic [RowW-1:0]  row_cnt_reg;
    logic [RowW-1:0]  addr_a, addr_b;
    logic [RowBits-1:0] row_a, row_b;

    assign load_en   = cmd.load && (32'(s_load_row) < MAX_HEIGHT)
                       && (32'(s_load_word_index) < WORDS_PER_ROW);
    assign load_addr = RowW'(s_load_row);
    assign addr_a    = ra_reg + row_cnt_reg;
    assign addr_b    = rb_reg + row_cnt_reg;

    for (genvar g = 0; g < WORDS_PER_ROW; g++) begin : g_bank
        logic [WordW-1:0] mem_a [MAX_HEIGHT];
        logic [WordW-1:0] mem_b [MAX_HEIGHT];
        logic [WordW-1:0] word_a_q, word_b_q;
        logic             sel_word;

        assign sel_word = load_en && (32'(s_load_word_index) == g);

        always_ff @(posedge aclk) begin
            if (sel_word && s_mask_select == SelMaskA) begin
                mem_a[load_addr] <= s_load_data;
            end
            if (sel_word && s_mask_select == SelMaskB) begin
                mem_b[load_addr] <= s_load_data;
            end
            if (cmd.issue) begin
                word_a_q <= mem_a[addr_a];
                word_b_q <= mem_b[addr_b];
            end
        end

        // word 0 holds the leftmost pixels
        assign row_a[RowBits-1-g*WordW -: WordW] = word_a_q;
        assign row_b[RowBits-1-g*WordW -: WordW] = word_b_q;
    end

    // row compare: unaligned windows, clipped to the overlap width
    logic [ExtBits-1:0]   ext_a_sh, ext_b_sh;
    logic [MAX_WIDTH-1:0] win_a, win_b, col_mask;
    logic                 row_hit;
    logic                 rd_valid_reg;
    logic                 hit_acc_reg;

    always_comb begin
        ext_a_sh = {row_a, {MAX_WIDTH{1'b0}}} << ca_reg;
        ext_b_sh = {row_b, {MAX_WIDTH{1'b0}}} << cb_reg;
        win_a    = ext_a_sh[ExtBits-1 -: MAX_WIDTH];
        win_b    = ext_b_sh[ExtBits-1 -: MAX_WIDTH];
        col_mask = ~({MAX_WIDTH{1'b1}} >> w_reg);
        row_hit  = |(win_a & win_b & col_mask);
    end

    always_ff @(posedge aclk) begin
        if (cmd.size) begin
            row_cnt_reg <= '0;
        end else if (cmd.issue) begin
            row_cnt_reg <= row_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            hit_acc_reg  <= 1'b0;
        end else if (cmd.size) begin
            rd_valid_reg <= 1'b0;
            hit_acc_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.issue;
            if (rd_valid_reg && row_hit) begin
                hit_acc_reg <= 1'b1;
            end
        end
    end

    assign status.empty    = empty_reg;
    assign status.last_row = ({1'b0, row_cnt_reg} == (h_reg - 1'b1));
    assign status.hit      = hit_acc_reg;
    assign status.busy     = rd_valid_reg;

    `BSC_ASSERT_IMPLIES(a_row_in_range, aclk, aresetn, cmd.issue, (32'(addr_a) < MAX_HEIGHT) && (32'(addr_b) < MAX_HEIGHT))
    `BSC_ASSERT_NEXT(a_hit_sticky, aclk, aresetn, hit_acc_reg && !cmd.size, hit_acc_reg)
    `BSC_ASSERT_NEXT(a_setup_flushes, aclk, aresetn, cmd.size, !rd_valid_reg && !hit_acc_reg)

endmodule

`default_nettype wire

FILE: design/bsc_ctrl.sv
// controller: sequences loads and tests, owns the result register
// depends on bsc_pkg and the assertion macro header
`default_nettype none
`include "bitmask_sprite_collision_top_defines.svh"

module bsc_ctrl import bsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output bsc_cmd_t    cmd,
    input  bsc_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUNDS,
        ST_CLIP,
        ST_SIZE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   m_hit_reg, m_hit_next;
    logic   in_fire;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_hit_next   = m_hit_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_kind == KindTest) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_BOUNDS;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_BOUNDS: begin
                cmd.bounds = 1'b1;
                state_next = ST_CLIP;
            end
            ST_CLIP: begin
                cmd.clip   = 1'b1;
                state_next = ST_SIZE;
            end
            ST_SIZE: begin
                cmd.size   = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                priority if (status.empty || status.hit) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.issue = 1'b1;
                    if (status.last_row) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (status.hit || !status.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = status.hit;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            m_hit_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            m_hit_reg   <= m_hit_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;

    `BSC_ASSERT_NEXT(a_test_blocks_input, aclk, aresetn, in_fire && (s_kind == KindTest), !s_ready)
    `BSC_ASSERT_NEXT(a_load_no_result, aclk, aresetn, in_fire && (s_kind == KindLoad) && !m_valid_reg, !m_valid_reg)
    `BSC_ASSERT_IMPLIES(a_no_walk_when_empty, aclk, aresetn, cmd.issue, !status.empty && !status.hit)

endmodule

`default_nettype wire

FILE: design/bitmask_sprite_collision_top.sv
// top level of the bitmask sprite collision block
// instantiates bsc_ctrl and bsc_datapath; uses bsc_pkg
`default_nettype none

// Pixel-exact collision test between two one-bit-per-pixel masks, A and B.
// Each mask lives in WORDS_PER_ROW banks of MAX_HEIGHT 32-bit words, word 0
// holding the leftmost pixels with the msb first. A load word (s_kind low)
// writes one mask word and returns nothing; loads past the MAX_HEIGHT rows
// or WORDS_PER_ROW words of a mask are dropped. A test word (s_kind high)
// places both sprites, adds the configured offsets, intersects the two
// rectangles and walks the overlap one row per cycle, returning one m_hit
// word. A test runs the bounds, clip and size setup steps, then walks the
// overlap rows (up to MAX_HEIGHT; none for an empty overlap), drains the
// last row read and compare, and posts the result; the walk is bounded by
// the single row read per cycle from the word banks. The walk stops early
// at the first common set pixel. The result register decouples the output:
// a new word is accepted while the previous result waits for m_ready. Mask
// words come up undefined after reset and must be loaded before a test
// reads them. Configuration writes are always accepted and must only be
// issued while the block is idle.

module bitmask_sprite_collision_top import bsc_pkg::*; #(
    parameter int unsigned MAX_WIDTH     = DefMaxWidth,
    parameter int unsigned MAX_HEIGHT    = DefMaxHeight,
    parameter int unsigned WORDS_PER_ROW = DefWordsPerRow
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CfgIdxW-1:0]     cfg_index,
    input  logic [CfgDataW-1:0]    cfg_data,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_kind,
    input  logic                   s_mask_select,
    input  logic [LoadRowW-1:0]    s_load_row,
    input  logic [LoadIdxW-1:0]    s_load_word_index,
    input  logic [WordW-1:0]       s_load_data,
    input  logic signed [PosW-1:0] s_pos_a_x,
    input  logic signed [PosW-1:0] s_pos_a_y,
    input  logic signed [PosW-1:0] s_pos_b_x,
    input  logic signed [PosW-1:0] s_pos_b_y,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_hit
);

    bsc_cmd_t    cmd;
    bsc_status_t status;
    logic        cfg_write;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // sequencing of loads and test phases, result register
    bsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_hit   (m_hit),
        .cmd     (cmd),
        .status  (status)
    );

    // config registers, mask banks, rectangle math and row compare
    bsc_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .WORDS_PER_ROW (WORDS_PER_ROW)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_mask_select     (s_mask_select),
        .s_load_row        (s_load_row),
        .s_load_word_index (s_load_word_index),
        .s_load_data       (s_load_data),
        .s_pos_a_x         (s_pos_a_x),
        .s_pos_a_y         (s_pos_a_y),
        .s_pos_b_x         (s_pos_b_x),
        .s_pos_b_y         (s_pos_b_y)
    );

endmodule

`default_nettype wire

FILE: test/bitmask_sprite_collision_top_test.sv
// self-checking testbench for bitmask_sprite_collision_top
// uses bsc_pkg for widths, word codes and register indexes; needs only the rtl
`timescale 1ns / 1ps

module bitmask_sprite_collision_top_test;
    import bsc_pkg::*;

    localparam int StoreDepth = DefMaxHeight * DefWordsPerRow;

    // one word on the input channel, load and test fields side by side
    typedef struct {
        logic                   kind;
        logic                   sel;
        logic [LoadRowW-1:0]    row;
        logic [LoadIdxW-1:0]    widx;
        logic [WordW-1:0]       data;
        logic signed [PosW-1:0] pax;
        logic signed [PosW-1:0] pay;
        logic signed [PosW-1:0] pbx;
        logic signed [PosW-1:0] pby;
    } sprite_word_t;

    // how many set pixels the loaded mask words carry
    typedef enum int {
        DENSITY_SPARSE,
        DENSITY_MIXED,
        DENSITY_DENSE
    } density_t;

    // receiver back-pressure patterns
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_RARE,
        READY_PERIODIC
    } ready_mode_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CfgIdxW-1:0]     cfg_index = '0;
    logic [CfgDataW-1:0]    cfg_data = '0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_kind = 1'b0;
    logic                   s_mask_select = 1'b0;
    logic [LoadRowW-1:0]    s_load_row = '0;
    logic [LoadIdxW-1:0]    s_load_word_index = '0;
    logic [WordW-1:0]       s_load_data = '0;
    logic signed [PosW-1:0] s_pos_a_x = '0;
    logic signed [PosW-1:0] s_pos_a_y = '0;
    logic signed [PosW-1:0] s_pos_b_x = '0;
    logic signed [PosW-1:0] s_pos_b_y = '0;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_hit;

    bitmask_sprite_collision_top i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_mask_select     (s_mask_select),
        .s_load_row        (s_load_row),
        .s_load_word_index (s_load_word_index),
        .s_load_data       (s_load_data),
        .s_pos_a_x         (s_pos_a_x),
        .s_pos_a_y         (s_pos_a_y),
        .s_pos_b_x         (s_pos_b_x),
        .s_pos_b_y         (s_pos_b_y),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow state of the block: register values and both mask stores
    // ------------------------------------------------------------------
    int          cfg_shadow [8];
    logic [31:0] mask_a [StoreDepth];
    logic [31:0] mask_b [StoreDepth];

    sprite_word_t pending_words [$];   // words waiting for the sender
    logic         expected_hits [$];   // hit bits still owed by the block
    sprite_word_t offered;             // word currently on the input channel

    int       mismatches = 0;
    int       n_loads = 0;
    int       n_tests = 0;
    int       n_hits = 0;
    int       n_checked = 0;
    int       n_reg_writes = 0;
    int       n_setups = 0;
    density_t phase_density = DENSITY_MIXED;
    logic     no_gaps = 1'b0;

    // sender and receiver pacing state
    int          burst_left = 0;
    int          gap_left = 0;
    ready_mode_t stall_mode = READY_ALWAYS;
    int          stall_len = 0;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // size register after saturation to the store limits
    function automatic int eff_size(input cfg_idx_t idx, input int limit);
        return (cfg_shadow[idx] > limit) ? limit : cfg_shadow[idx];
    endfunction

    // mask word with out-of-range rows and words reading as zero
    function automatic logic [31:0] store_word(input logic is_b, input int row, input int wi);
        if (row < 0 || row >= DefMaxHeight || wi < 0 || wi >= DefWordsPerRow)
            return '0;
        return is_b ? mask_b[row * DefWordsPerRow + wi] : mask_a[row * DefWordsPerRow + wi];
    endfunction

    // 32 pixels starting at an unaligned column, bits past 'left' cleared
    function automatic logic [31:0] mask_chunk(input logic is_b, input int row, input int col,
                                               input int left);
        int          wi;
        int          sh;
        logic [31:0] r;
        wi = col / 32;
        sh = col % 32;
        r = store_word(is_b, row, wi);
        if (sh != 0)
            r = (r << sh) | (store_word(is_b, row, wi + 1) >> (32 - sh));
        if (left < 32)
            r &= ~((32'd1 << (32 - left)) - 32'd1);
        return r;
    endfunction

    // rectangle intersection followed by a row-by-row walk of the overlap
    function automatic logic predict_hit(input sprite_word_t w);
        int ax, ay, aw, ah, bx, by, bw, bh;
        int x0, y0, x1, y1, ow, oh;
        ax = int'(w.pax) + cfg_shadow[CFG_OFFSET_A_X];
        ay = int'(w.pay) + cfg_shadow[CFG_OFFSET_A_Y];
        bx = int'(w.pbx) + cfg_shadow[CFG_OFFSET_B_X];
        by = int'(w.pby) + cfg_shadow[CFG_OFFSET_B_Y];
        aw = eff_size(CFG_WIDTH_A, DefMaxWidth);
        ah = eff_size(CFG_HEIGHT_A, DefMaxHeight);
        bw = eff_size(CFG_WIDTH_B, DefMaxWidth);
        bh = eff_size(CFG_HEIGHT_B, DefMaxHeight);
        if (aw <= 0 || ah <= 0 || bw <= 0 || bh <= 0)
            return 1'b0;
        x0 = (ax > bx) ? ax : bx;
        y0 = (ay > by) ? ay : by;
        x1 = (ax + aw < bx + bw) ? ax + aw : bx + bw;
        y1 = (ay + ah < by + bh) ? ay + ah : by + bh;
        ow = x1 - x0;
        oh = y1 - y0;
        if (ow <= 0 || oh <= 0)
            return 1'b0;
        for (int r = 0; r < oh; r++) begin
            for (int c = 0; c < ow; c += 32) begin
                if ((mask_chunk(1'b0, r + y0 - ay, c + x0 - ax, ow - c) &
                     mask_chunk(1'b1, r + y0 - by, c + x0 - bx, ow - c)) != 0)
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------
    function automatic int rand_pos();
        return $urandom_range(0, 65535) - 32768;
    endfunction

    function automatic sprite_word_t make_load(input logic sel, input int row, input int widx,
                                               input logic [WordW-1:0] data);
        sprite_word_t w;
        w.kind = KindLoad;
        w.sel  = sel;
        w.row  = row[LoadRowW-1:0];
        w.widx = widx[LoadIdxW-1:0];
        w.data = data;
        // position fields are don't-care for loads, keep them moving
        w.pax = PosW'($urandom);
        w.pay = PosW'($urandom);
        w.pbx = PosW'($urandom);
        w.pby = PosW'($urandom);
        return w;
    endfunction

    function automatic sprite_word_t make_test(input int ax, input int ay, input int bx,
                                               input int by);
        sprite_word_t w;
        w.kind = KindTest;
        w.sel  = 1'($urandom);
        w.row  = LoadRowW'($urandom);
        w.widx = LoadIdxW'($urandom);
        w.data = $urandom;
        w.pax  = ax[PosW-1:0];
        w.pay  = ay[PosW-1:0];
        w.pbx  = bx[PosW-1:0];
        w.pby  = by[PosW-1:0];
        return w;
    endfunction

    function automatic logic [WordW-1:0] mask_data(input density_t level);
        int pick;
        pick = $urandom_range(0, 99);
        case (level)
            DENSITY_SPARSE: begin
                return (pick < 85) ? '0 : (32'd1 << $urandom_range(0, 31));
            end
            DENSITY_MIXED: begin
                return (pick < 50) ? '0 : ($urandom & $urandom & $urandom);
            end
            default: begin
                return (pick < 10) ? '1 : $urandom;
            end
        endcase
    endfunction

    function automatic int rand_size();
        case ($urandom_range(0, 5))
            0: begin
                return 0;
            end
            1: begin
                return 1;
            end
            2: begin
                return $urandom_range(65, 127);
            end
            default: begin
                return $urandom_range(1, 64);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sender: bursts of words with random gaps, fed from pending_words
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : sender
        logic next_valid;
        next_valid = s_valid;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                // word taken: update the shadow stores or queue the expected hit
                if (offered.kind == KindLoad) begin
                    n_loads++;
                    if (offered.row < DefMaxHeight && offered.widx < DefWordsPerRow) begin
                        if (offered.sel == SelMaskB)
                            mask_b[offered.row * DefWordsPerRow + offered.widx] = offered.data;
                        else
                            mask_a[offered.row * DefWordsPerRow + offered.widx] = offered.data;
                    end
                end else begin
                    n_tests++;
                    expected_hits.push_back(predict_hit(offered));
                    if (expected_hits[$])
                        n_hits++;
                end
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() != 0) begin
                    offered = pending_words.pop_front();
                    s_kind            <= offered.kind;
                    s_mask_select     <= offered.sel;
                    s_load_row        <= offered.row;
                    s_load_word_index <= offered.widx;
                    s_load_data       <= offered.data;
                    s_pos_a_x         <= offered.pax;
                    s_pos_a_y         <= offered.pay;
                    s_pos_b_x         <= offered.pbx;
                    s_pos_b_y         <= offered.pby;
                    next_valid = 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 16);
                    burst_left--;
                    // end of burst: mostly a short gap, now and then a long one
                    if (burst_left == 0 && !no_gaps) begin
                        case ($urandom_range(0, 7))
                            0, 1: gap_left = 0;
                            7: gap_left = $urandom_range(20, 60);
                            default: gap_left = $urandom_range(1, 12);
                        endcase
                    end
                end
            end
        end
        s_valid <= next_valid;
    end

    // ------------------------------------------------------------------
    // receiver: checks each hit word, stalls on a changing pattern
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : receiver
        logic want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_checked++;
                if (expected_hits.size() == 0) begin
                    report_mismatch($sformatf("hit word %b with no test pending", m_hit));
                end else begin
                    want = expected_hits.pop_front();
                    if (m_hit !== want)
                        report_mismatch($sformatf("hit is %b, expected %b", m_hit, want));
                end
            end
            if (stall_len == 0) begin
                stall_mode = ready_mode_t'($urandom_range(0, 3));
                stall_len = $urandom_range(32, 300);
            end
            stall_len--;
            case (stall_mode)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_COIN: m_ready <= 1'($urandom_range(0, 1));
                READY_RARE: m_ready <= ($urandom_range(0, 7) == 0);
                default: m_ready <= (stall_len % 5) < 2;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequencing
    // ------------------------------------------------------------------

    // block idle: nothing queued, nothing offered, nothing owed, then a wait
    // so a trailing load has landed
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_hits.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        logic [CfgDataW-1:0] keep;
        logic [CfgDataW-1:0] data;
        keep = (idx == CFG_WIDTH_A || idx == CFG_HEIGHT_A ||
                idx == CFG_WIDTH_B || idx == CFG_HEIGHT_B) ? CfgDataW'((1 << SizeW) - 1) :
               CfgDataW'((1 << OffW) - 1);
        data = value[CfgDataW-1:0] & keep;
        // junk above the register width half the time, the block drops it
        if ($urandom_range(0, 1))
            data |= CfgDataW'($urandom) & ~keep;
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_shadow[idx] = int'(data & keep);
        n_reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int oax, input int oay, input int aw, input int ah,
                              input int obx, input int oby, input int bw, input int bh);
        int vals [8];
        vals = '{oax, oay, aw, ah, obx, oby, bw, bh};
        for (int i = 0; i < 8; i++)
            write_reg(cfg_idx_t'(i), vals[i]);
        n_setups++;
        phase_density = density_t'($urandom_range(0, 2));
    endtask

    // mostly aimed tests, some loads into random rows and some scattered noise
    task automatic run_random(input int count);
        int ax, ay, bx, by, aw, ah, bw, bh;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 3) begin
                pending_words.push_back(make_load(1'($urandom_range(0, 1)),
                                                  $urandom_range(0, 63),
                                                  ($urandom_range(0, 7) == 0) ? 3 :
                                                  $urandom_range(0, 2),
                                                  mask_data(phase_density)));
            end else begin
                aw = eff_size(CFG_WIDTH_A, DefMaxWidth);
                ah = eff_size(CFG_HEIGHT_A, DefMaxHeight);
                bw = eff_size(CFG_WIDTH_B, DefMaxWidth);
                bh = eff_size(CFG_HEIGHT_B, DefMaxHeight);
                ax = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 32767 : -32768) :
                     rand_pos();
                ay = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 32767 : -32768) :
                     rand_pos();
                if ($urandom_range(0, 7) == 0) begin
                    bx = rand_pos();
                    by = rand_pos();
                end else begin
                    // place B so the rectangles overlap or just miss
                    bx = ax + cfg_shadow[CFG_OFFSET_A_X] - cfg_shadow[CFG_OFFSET_B_X] +
                         int'($urandom_range(0, aw + bw + 4)) - bw - 2;
                    by = ay + cfg_shadow[CFG_OFFSET_A_Y] - cfg_shadow[CFG_OFFSET_B_Y] +
                         int'($urandom_range(0, ah + bh + 4)) - bh - 2;
                end
                if (bx > 32767) bx = 32767;
                if (bx < -32768) bx = -32768;
                if (by > 32767) by = 32767;
                if (by < -32768) by = -32768;
                pending_words.push_back(make_test(ax, ay, bx, by));
            end
        end
    endtask

    initial begin : stimulus
        density_t row_density;
        for (int i = 0; i < StoreDepth; i++) begin
            mask_a[i] = '0;
            mask_b[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            cfg_shadow[i] = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // every mask word gets loaded before any test can read it
        for (int sel = 0; sel < 2; sel++) begin
            for (int row = 0; row < DefMaxHeight; row++) begin
                row_density = density_t'($urandom_range(0, 2));
                for (int wi = 0; wi < DefWordsPerRow; wi++)
                    pending_words.push_back(make_load(1'(sel), row, wi,
                                                      mask_data(row_density)));
            end
        end
        // sizes are still zero after reset: empty masks never hit
        pending_words.push_back(make_test(0, 0, 0, 0));
        wait_drained();

        // directed checks with both masks at full size and no offsets
        set_config(0, 0, 64, 64, 0, 0, 64, 64);
        pending_words.push_back(make_test(0, 0, 0, 0));
        pending_words.push_back(make_test(-32768, -32768, -32768, -32768));
        pending_words.push_back(make_test(32767, 32767, 32767, 32767));
        pending_words.push_back(make_test(0, 0, 64, 0));          // edges touch, no overlap
        pending_words.push_back(make_test(0, 0, 0, -64));
        pending_words.push_back(make_test(0, 0, 63, 63));         // single corner pixel
        pending_words.push_back(make_test(0, 0, -63, -63));
        pending_words.push_back(make_test(5, 0, -27, 3));         // unaligned chunks
        pending_words.push_back(make_test(-32768, 0, 32767, 0));  // far apart
        pending_words.push_back(make_load(SelMaskA, 0, 0, '1));
        pending_words.push_back(make_load(SelMaskB, 0, 0, '1));
        pending_words.push_back(make_test(0, 0, 0, 0));           // first row collides
        pending_words.push_back(make_load(SelMaskA, 0, 3, '0));   // word index past row, dropped
        pending_words.push_back(make_load(SelMaskB, 63, 3, '0));
        pending_words.push_back(make_test(0, 0, 0, 0));
        pending_words.push_back(make_load(SelMaskA, 63, 2, '1));  // padding word
        pending_words.push_back(make_load(SelMaskB, 63, 1, '1));
        pending_words.push_back(make_test(0, 0, -33, 0));
        pending_words.push_back(make_test(-1, 0, 31, 0));
        pending_words.push_back(make_load(SelMaskA, 0, 0, '0));
        pending_words.push_back(make_test(0, 0, 0, 0));
        wait_drained();
        run_random(24);
        wait_drained();

        // oversized sizes saturate, offsets at their top value
        set_config(1023, 1023, 127, 100, 1023, 1023, 65, 127);
        run_random(24);
        wait_drained();

        // single-pixel masks, back to back words
        no_gaps = 1'b1;
        set_config(0, 1023, 1, 1, 1023, 0, 1, 1);
        run_random(24);
        wait_drained();
        no_gaps = 1'b0;

        // widths off the word grid so padding bits take part; the sender
        // holds off halfway until every owed hit is back
        set_config($urandom_range(0, 1023), $urandom_range(0, 1023), 40, 17,
                   $urandom_range(0, 1023), $urandom_range(0, 1023), 33, 64);
        run_random(12);
        wait_drained();
        run_random(12);
        wait_drained();

        // one mask empty in each direction
        set_config($urandom_range(0, 1023), $urandom_range(0, 1023), 0, 64,
                   $urandom_range(0, 1023), $urandom_range(0, 1023), 64, 64);
        run_random(16);
        wait_drained();
        set_config($urandom_range(0, 1023), $urandom_range(0, 1023), 64, 64,
                   $urandom_range(0, 1023), $urandom_range(0, 1023), 64, 0);
        run_random(16);
        wait_drained();

        // word-sized boundaries
        set_config(1023, 0, 31, 32, 0, 1023, 32, 31);
        run_random(24);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            set_config($urandom_range(0, 1023), $urandom_range(0, 1023), rand_size(),
                       rand_size(), $urandom_range(0, 1023), $urandom_range(0, 1023),
                       rand_size(), rand_size());
            run_random(22);
            wait_drained();
        end

        repeat (80) @(posedge aclk);
        if (expected_hits.size() != 0)
            report_mismatch($sformatf("%0d hit words never arrived", expected_hits.size()));
        $display("covered %0d loads and %0d tests (%0d hits) over %0d register setups",
                 n_loads, n_tests, n_hits, n_setups);
        $display("%0d hit words checked, %0d register writes, %0d mismatches",
                 n_checked, n_reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("bitmask_sprite_collision_top_test OK");
        end else begin
            $display("bitmask_sprite_collision_top_test NOT OK");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("timeout with %0d words queued and %0d hits owed",
                 pending_words.size(), expected_hits.size());
        $display("bitmask_sprite_collision_top_test NOT OK");
        $finish;
    end

endmodule
